FILE: rtl/core/bhx_pkg.sv
`timescale 1ns / 1ps

package bhx_pkg;

   // Fixed widths of the transaction fields.
   localparam int DATA_W = 32;
   localparam int IDX_W  = 6;
   localparam int IDX_N  = 64;
   localparam int ROW_W  = 2;

   // One lane per column of the result row.
   localparam int LANES  = 4;
   localparam int PROD_W = 2 * DATA_W;
   // Four exact products plus the rounding constant need two guard bits.
   localparam int ACC_W  = PROD_W + 2;

   // Result transactions that may be accepted and not yet delivered.
   localparam int OUT_DEPTH = 4;
   localparam int OUT_PTR_W = 2;
   localparam int OUT_CNT_W = 3;

   localparam logic [ROW_W-1:0] LAST_ROW = 2'd3;
   localparam logic [ROW_W-1:0] FIRST_ROW = 2'd0;

   typedef logic signed [DATA_W-1:0] word_type;
   typedef word_type [LANES-1:0] row_type;
   typedef logic signed [ACC_W-1:0] acc_type;
   typedef acc_type [LANES-1:0] acc_row_type;

   // Control of the accumulate step of every lane.
   typedef struct packed {
      logic acc_en;
      logic first;
   } lane_ctl_type;

   // Item identity carried alongside the datapath.
   typedef struct packed {
      logic [IDX_W-1:0] bone;
      logic [ROW_W-1:0] row;
      logic             root;
   } meta_type;

   // One finished result transaction.
   typedef struct packed {
      logic [IDX_W-1:0] bone;
      logic [ROW_W-1:0] row;
      row_type          model;
      logic             sat;
   } rsp_type;

endpackage

FILE: rtl/core/bhx_lane.sv
`timescale 1ns / 1ps

module bhx_lane #(
   parameter int FRAC_BITS = 16
) (
   input  logic                  clock,
   input  bhx_pkg::word_type     loc_word,
   input  bhx_pkg::word_type     par_word,
   input  bhx_pkg::lane_ctl_type ctl,
   output bhx_pkg::acc_type      acc
);
   import bhx_pkg::*;

   // Rounding constant of one half, folded into the first accumulate step.
   localparam acc_type RND = ACC_W'(1) << (FRAC_BITS - 1);

   logic signed [PROD_W-1:0] prod_in;
   logic signed [PROD_W-1:0] prod_ff;
   acc_type                  acc_in;
   acc_type                  acc_ff;

   assign prod_in = loc_word * par_word;

   always_comb begin
      acc_in = (ctl.first ? RND : acc_ff) + ACC_W'(prod_ff);
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      if (ctl.acc_en) begin
         acc_ff <= acc_in;
      end
   end

   assign acc = acc_ff;

endmodule

FILE: rtl/core/bhx_merge.sv
`timescale 1ns / 1ps

module bhx_merge #(
   parameter int FRAC_BITS = 16
) (
   input  bhx_pkg::acc_row_type acc_row,
   output bhx_pkg::row_type     model,
   output logic                 sat
);
   import bhx_pkg::*;

   localparam word_type WORD_MAX = {1'b0, {(DATA_W - 1){1'b1}}};
   localparam word_type WORD_MIN = {1'b1, {(DATA_W - 1){1'b0}}};

   acc_type          shifted [LANES];
   logic [LANES-1:0] clamp;

   // Drop the fraction bits and clamp each column to the 32-bit range.
   always_comb begin
      for (int j = 0; j < LANES; j++) begin
         shifted[j] = acc_row[j] >>> FRAC_BITS;
         clamp[j] = !((&shifted[j][ACC_W-1:DATA_W-1]) || !(|shifted[j][ACC_W-1:DATA_W-1]));
         if (!clamp[j]) begin
            model[j] = shifted[j][DATA_W-1:0];
         end else if (shifted[j][ACC_W-1]) begin
            model[j] = WORD_MIN;
         end else begin
            model[j] = WORD_MAX;
         end
      end
      sat = |clamp;
   end

endmodule

FILE: rtl/core/bhx_out_fifo.sv
`timescale 1ns / 1ps

module bhx_out_fifo (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  bhx_pkg::rsp_type push_data,
   input  logic             pop,
   output logic             out_valid,
   output bhx_pkg::rsp_type out_data
);
   import bhx_pkg::*;

   rsp_type                entry_ff [OUT_DEPTH];
   logic [OUT_PTR_W-1:0]   wr_ptr_ff;
   logic [OUT_PTR_W-1:0]   wr_ptr_in;
   logic [OUT_PTR_W-1:0]   rd_ptr_ff;
   logic [OUT_PTR_W-1:0]   rd_ptr_in;
   logic [OUT_CNT_W-1:0]   count_ff;
   logic [OUT_CNT_W-1:0]   count_in;

   // The caller never pushes into a full queue, so push needs no guard here.
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + OUT_PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + OUT_PTR_W'(1) : rd_ptr_ff;
      count_in = count_ff + OUT_CNT_W'(push) - OUT_CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign out_valid = (count_ff != '0);
   assign out_data = entry_ff[rd_ptr_ff];

endmodule

FILE: rtl/core/bone_hierarchy_transform_unit.sv
`timescale 1ns / 1ps

// Forward kinematics over a bone table that is fed parents first. Each request transaction
// carries one row of a bone's local 4x4 transform in signed fixed point with FRAC_BITS fraction
// bits, plus the bone index, the parent index and a root flag. A root row passes through
// unchanged; any other row is multiplied by the parent's stored model matrix, rounded half up,
// saturated to 32 bits, written back to the model store and returned on the response channel.
// Four column lanes multiply and accumulate side by side while the parent matrix is read from
// the store one row per cycle, so a request occupies the store read port while its four parent
// rows are read, and the next request can enter while the last of them is read. A request whose
// parent is a bone still in the pipeline waits until that row has been written.
// Up to four transactions can be in flight or waiting for delivery; when the receiver stalls,
// results collect in a small output queue and req_stall rises once that queue would be full.
// Reset clears the sequencer, the pipeline valid bits and the output queue. The model store is
// not cleared: a parent row must be written before a child reads it.
module bone_hierarchy_transform_unit #(
   parameter int MAX_BONES = 64,
   parameter int FRAC_BITS = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [bhx_pkg::IDX_W-1:0]           req_bone_index,
   input  logic [bhx_pkg::IDX_W-1:0]           req_parent_index,
   input  logic                                req_is_root,
   input  logic [bhx_pkg::ROW_W-1:0]           req_row_index,
   input  logic signed [bhx_pkg::DATA_W-1:0]   req_local_c0,
   input  logic signed [bhx_pkg::DATA_W-1:0]   req_local_c1,
   input  logic signed [bhx_pkg::DATA_W-1:0]   req_local_c2,
   input  logic signed [bhx_pkg::DATA_W-1:0]   req_local_c3,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [bhx_pkg::IDX_W-1:0]           rsp_out_bone,
   output logic [bhx_pkg::ROW_W-1:0]           rsp_out_row,
   output logic signed [bhx_pkg::DATA_W-1:0]   rsp_model_c0,
   output logic signed [bhx_pkg::DATA_W-1:0]   rsp_model_c1,
   output logic signed [bhx_pkg::DATA_W-1:0]   rsp_model_c2,
   output logic signed [bhx_pkg::DATA_W-1:0]   rsp_model_c3,
   output logic                                rsp_saturated
);
   import bhx_pkg::*;

   localparam int SLOT_W = (MAX_BONES > 1) ? $clog2(MAX_BONES) : 1;
   localparam int ROWS = MAX_BONES * 4;
   localparam int ADDR_W = $clog2(ROWS);
   localparam word_type ONE = DATA_W'(1) << FRAC_BITS;

   typedef logic [SLOT_W-1:0] slot_type;
   typedef slot_type [IDX_N-1:0] slot_tab_type;

   // Bone indices wrap at MAX_BONES when they address the store.
   function automatic slot_tab_type make_slots();
      slot_tab_type tab;
      for (int i = 0; i < IDX_N; i++) begin
         tab[i] = SLOT_W'(i % MAX_BONES);
      end
      return tab;
   endfunction

   localparam slot_tab_type SLOT_TAB = make_slots();

   // Handshake and bookkeeping.
   logic                 req_accept;
   logic                 rsp_pop;
   logic                 can_take;
   logic                 hazard;
   slot_type             req_bslot;
   slot_type             req_pslot;
   logic [OUT_CNT_W-1:0] occ_ff;
   logic [OUT_CNT_W-1:0] occ_in;

   // Sequencer that walks the four parent rows.
   logic                 busy_ff;
   logic                 busy_in;
   logic [ROW_W-1:0]     k_ff;
   logic [ROW_W-1:0]     k_in;
   meta_type             cur_meta_ff;
   slot_type             cur_bslot_ff;
   slot_type             cur_pslot_ff;
   row_type              cur_loc_ff;

   // Model store, one 128-bit matrix row per entry.
   row_type              store_mem [ROWS];
   row_type              rd_data_ff;
   logic [ADDR_W-1:0]    rd_addr;
   logic [ADDR_W-1:0]    wr_addr;

   // Pipeline stages behind the store read.
   logic                 s1_valid_ff;
   logic [ROW_W-1:0]     s1_k_ff;
   meta_type             s1_meta_ff;
   slot_type             s1_bslot_ff;
   word_type             s1_loc_ff;
   logic                 s2_valid_ff;
   logic [ROW_W-1:0]     s2_k_ff;
   meta_type             s2_meta_ff;
   slot_type             s2_bslot_ff;
   logic                 s3_valid_ff;
   meta_type             s3_meta_ff;
   slot_type             s3_bslot_ff;

   row_type              par_row;
   lane_ctl_type         lane_ctl;
   acc_row_type          acc_row;
   row_type              merged_row;
   logic                 merged_sat;
   rsp_type              push_data;
   rsp_type              head;

   assign req_bslot = SLOT_TAB[req_bone_index];
   assign req_pslot = SLOT_TAB[req_parent_index];

   // A new request may enter while the last parent row of the current one is read. It waits
   // while its parent is the bone of any transaction whose row would not reach the store
   // before the first parent row is read.
   always_comb begin
      can_take = !busy_ff || (k_ff == LAST_ROW);
      hazard = !req_is_root &&
               ((busy_ff && (cur_bslot_ff == req_pslot)) ||
                (s1_valid_ff && (s1_bslot_ff == req_pslot)) ||
                (s2_valid_ff && (s2_bslot_ff == req_pslot)));
      req_stall = !can_take || hazard || (occ_ff == OUT_CNT_W'(OUT_DEPTH));
   end

   assign req_accept = req_valid && !req_stall;
   assign rsp_pop = rsp_valid && !rsp_stall;

   // Credits: every accepted transaction owns a place in the output queue until delivered.
   always_comb begin
      occ_in = occ_ff + OUT_CNT_W'(req_accept) - OUT_CNT_W'(rsp_pop);
   end

   always_comb begin
      if (req_accept) begin
         busy_in = 1'b1;
         k_in = FIRST_ROW;
      end else if (busy_ff) begin
         busy_in = (k_ff != LAST_ROW);
         k_in = k_ff + ROW_W'(1);
      end else begin
         busy_in = 1'b0;
         k_in = k_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         occ_ff <= '0;
         busy_ff <= 1'b0;
         k_ff <= FIRST_ROW;
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else begin
         occ_ff <= occ_in;
         busy_ff <= busy_in;
         k_ff <= k_in;
         s1_valid_ff <= busy_ff;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff && (s2_k_ff == LAST_ROW);
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         cur_meta_ff <= '{bone: req_bone_index, row: req_row_index, root: req_is_root};
         cur_bslot_ff <= req_bslot;
         cur_pslot_ff <= req_pslot;
         cur_loc_ff <= {req_local_c3, req_local_c2, req_local_c1, req_local_c0};
      end
      s1_k_ff <= k_ff;
      s1_meta_ff <= cur_meta_ff;
      s1_bslot_ff <= cur_bslot_ff;
      s1_loc_ff <= cur_loc_ff[k_ff];
      s2_k_ff <= s1_k_ff;
      s2_meta_ff <= s1_meta_ff;
      s2_bslot_ff <= s1_bslot_ff;
      s3_meta_ff <= s2_meta_ff;
      s3_bslot_ff <= s2_bslot_ff;
   end

   // Store: one row read per cycle while the sequencer runs, one row written per result.
   assign rd_addr = ADDR_W'({cur_pslot_ff, k_ff});
   assign wr_addr = ADDR_W'({s3_bslot_ff, s3_meta_ff.row});

   always_ff @(posedge clock) begin
      if (busy_ff) begin
         rd_data_ff <= store_mem[rd_addr];
      end
      if (s3_valid_ff) begin
         store_mem[wr_addr] <= merged_row;
      end
   end

   // A root bone multiplies by the identity, which reproduces its local row exactly.
   always_comb begin
      for (int j = 0; j < LANES; j++) begin
         if (s1_meta_ff.root) begin
            par_row[j] = (ROW_W'(j) == s1_k_ff) ? ONE : '0;
         end else begin
            par_row[j] = rd_data_ff[j];
         end
      end
      lane_ctl.acc_en = s2_valid_ff;
      lane_ctl.first = (s2_k_ff == FIRST_ROW);
   end

   for (genvar j = 0; j < LANES; j++) begin : g_lane
      bhx_lane #(
         .FRAC_BITS(FRAC_BITS)
      ) u_lane (
         .clock   (clock),
         .loc_word(s1_loc_ff),
         .par_word(par_row[j]),
         .ctl     (lane_ctl),
         .acc     (acc_row[j])
      );
   end

   bhx_merge #(
      .FRAC_BITS(FRAC_BITS)
   ) u_merge (
      .acc_row(acc_row),
      .model  (merged_row),
      .sat    (merged_sat)
   );

   assign push_data = '{bone: s3_meta_ff.bone, row: s3_meta_ff.row,
                        model: merged_row, sat: merged_sat};

   bhx_out_fifo u_out_fifo (
      .clock    (clock),
      .reset    (reset),
      .push     (s3_valid_ff),
      .push_data(push_data),
      .pop      (rsp_pop),
      .out_valid(rsp_valid),
      .out_data (head)
   );

   assign rsp_out_bone = head.bone;
   assign rsp_out_row = head.row;
   assign rsp_model_c0 = head.model[0];
   assign rsp_model_c1 = head.model[1];
   assign rsp_model_c2 = head.model[2];
   assign rsp_model_c3 = head.model[3];
   assign rsp_saturated = head.sat;

endmodule

FILE: rtl/core/bhx_checker.sv
`timescale 1ns / 1ps

module bhx_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_valid,
   input logic                              req_stall,
   input logic                              rsp_valid,
   input logic                              rsp_stall,
   input logic [bhx_pkg::IDX_W-1:0]         rsp_out_bone,
   input logic [bhx_pkg::ROW_W-1:0]         rsp_out_row,
   input logic signed [bhx_pkg::DATA_W-1:0] rsp_model_c0,
   input logic                              rsp_saturated
);
   import bhx_pkg::*;

   logic req_take;

   assign req_take = req_valid && !req_stall;

   // A new request is taken only once the last parent row of the previous one is being read.
   a_req_spacing: assert property (@(posedge clock) disable iff (reset)
      req_take |=> !req_take ##1 !req_take ##1 !req_take)
      else $error("request accepted during parent row reads");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_out_bone) &&
                                    $stable(rsp_out_row) && $stable(rsp_model_c0) &&
                                    $stable(rsp_saturated)))
      else $error("stalled response changed");

endmodule

bind bone_hierarchy_transform_unit bhx_checker u_bhx_checker (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req_valid),
   .req_stall    (req_stall),
   .rsp_valid    (rsp_valid),
   .rsp_stall    (rsp_stall),
   .rsp_out_bone (rsp_out_bone),
   .rsp_out_row  (rsp_out_row),
   .rsp_model_c0 (rsp_model_c0),
   .rsp_saturated(rsp_saturated)
);
